[sv/lesc_pkg.sv]
// Shared types, codes and defaults of the LOOK elevator scheduler.
package lesc_pkg;

	localparam int DEF_STOP_DEPTH = 16;
	localparam int DEF_FLOOR_BITS = 6;
	localparam int DEF_TAG_BITS   = 8;

	localparam int KIND_W     = 3;
	localparam int DIR_W      = 2;
	localparam int STAT_W     = 3;
	localparam int LOAD_W     = 6;
	localparam int LFSR_W     = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;
	localparam logic [LFSR_W-1:0] LFSR_ONE  = 16'h0001;

	typedef enum logic [KIND_W-1:0] {
		KIND_ACCEPT  = 3'd0,
		KIND_REJECT  = 3'd1,
		KIND_FULL    = 3'd2,
		KIND_SUM     = 3'd3,
		KIND_PICKUP  = 3'd4,
		KIND_DROPOFF = 3'd5
	} kind_t;

	typedef enum logic [DIR_W-1:0] {
		DIR_IDLE = 2'd0,
		DIR_UP   = 2'd1,
		DIR_DOWN = 2'd2
	} dir_t;

	typedef enum logic [STAT_W-1:0] {
		ST_IDLE    = 3'd0,
		ST_UP      = 3'd1,
		ST_DOWN    = 3'd2,
		ST_PICKUP  = 3'd3,
		ST_DROPOFF = 3'd4
	} stat_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GROUND = 2'd0,
		CFG_TOP    = 2'd1,
		CFG_SEED   = 2'd2
	} cfg_t;

	typedef struct packed {
		logic latch;
		logic call;
		logic tick;
		logic scan;
		logic move;
		logic serve_step;
		logic serve_end;
		logic pick;
		logic append;
		logic turn;
		logic sum;
	} cmd_t;

	typedef struct packed {
		logic both_empty;
		logic rev_idle;
		logic scan_done;
		logic serve_done;
		logic sv_keep;
		logic sv_pick;
		logic sv_drop;
		logic div_done;
		logic append_done;
		logic out_free;
	} dp_stat_t;

endpackage

[sv/lesc_call_if.sv]
// Input channel: hall calls and scheduling ticks.
interface lesc_call_if #(
	parameter int FLOOR_BITS = 6,
	parameter int TAG_BITS   = 8
);
	logic                  valid;
	logic                  ready;
	logic                  mode;
	logic [FLOOR_BITS-1:0] call_floor;
	logic [1:0]            call_direction;
	logic [TAG_BITS-1:0]   call_tag;

	modport source (output valid, mode, call_floor, call_direction, call_tag, input ready);
	modport sink   (input valid, mode, call_floor, call_direction, call_tag, output ready);
endinterface

[sv/lesc_res_if.sv]
// Output channel: scheduler events.
interface lesc_res_if #(
	parameter int FLOOR_BITS = 6,
	parameter int TAG_BITS   = 8
);
	logic                  valid;
	logic                  ready;
	logic [2:0]            kind;
	logic [FLOOR_BITS-1:0] at_floor;
	logic [1:0]            moving_dir;
	logic [2:0]            car_status;
	logic [5:0]            load;
	logic [TAG_BITS-1:0]   event_tag;
	logic [FLOOR_BITS-1:0] dest_floor;
	logic                  last;

	modport source (output valid, kind, at_floor, moving_dir, car_status, load, event_tag,
		dest_floor, last, input ready);
	modport sink   (input valid, kind, at_floor, moving_dir, car_status, load, event_tag,
		dest_floor, last, output ready);
endinterface

[sv/lesc_ctrl.sv]
// Sequencer of the scheduler: steps the datapath through a call or a tick.
module lesc_ctrl import lesc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_mode,
	output logic     in_ready,
	output cmd_t     cmd,
	input  dp_stat_t stat
);

	typedef enum logic [10:0] {
		S_IDLE   = 11'b000_0000_0001,
		S_CALL   = 11'b000_0000_0010,
		S_TICK   = 11'b000_0000_0100,
		S_SCAN   = 11'b000_0000_1000,
		S_MOVE   = 11'b000_0001_0000,
		S_SERVE  = 11'b000_0010_0000,
		S_DIV    = 11'b000_0100_0000,
		S_PICK   = 11'b000_1000_0000,
		S_APPEND = 11'b001_0000_0000,
		S_TURN   = 11'b010_0000_0000,
		S_SUM    = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = in_mode ? S_TICK : S_CALL;
				end
			end
			S_CALL: begin
				if (stat.out_free) begin
					cmd.call = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_TICK: begin
				if (stat.both_empty) begin
					state_d = S_SUM;
				end else begin
					cmd.tick = 1'b1;
					state_d  = stat.rev_idle ? S_SCAN : S_MOVE;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_done) state_d = S_MOVE;
			end
			S_MOVE: begin
				cmd.move = 1'b1;
				state_d  = S_SERVE;
			end
			S_SERVE: begin
				priority if (stat.serve_done) begin
					cmd.serve_end = 1'b1;
					state_d       = S_APPEND;
				end else if (stat.sv_pick) begin
					cmd.serve_step = 1'b1;
					state_d        = S_DIV;
				end else if (stat.sv_keep || (stat.sv_drop && stat.out_free)) begin
					cmd.serve_step = 1'b1;
				end
			end
			S_DIV: begin
				if (stat.div_done) state_d = S_PICK;
			end
			S_PICK: begin
				if (stat.out_free) begin
					cmd.pick = 1'b1;
					state_d  = S_SERVE;
				end
			end
			S_APPEND: begin
				if (stat.append_done) state_d = S_TURN;
				else cmd.append = 1'b1;
			end
			S_TURN: begin
				cmd.turn = 1'b1;
				state_d  = S_SUM;
			end
			S_SUM: begin
				if (stat.out_free) begin
					cmd.sum = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

endmodule

[sv/lesc_mod.sv]
// Bit-serial remainder unit: one dividend bit per cycle.
module lesc_mod import lesc_pkg::*; #(
	parameter int SW = DEF_FLOOR_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [LFSR_W-1:0] dividend,
	input  logic [SW-1:0]     divisor,
	output logic              done,
	output logic [SW-1:0]     rem
);

	localparam int CW = $clog2(LFSR_W);

	logic              busy_q;
	logic [CW-1:0]     cnt_q;
	logic [LFSR_W-1:0] num_q;
	logic [SW-1:0]     rem_q;
	logic [SW-1:0]     div_q;
	logic [SW:0]       trial;
	logic [SW-1:0]     rem_nx;

	assign trial  = {rem_q, num_q[LFSR_W-1]};
	assign rem_nx = (trial >= {1'b0, div_q}) ? SW'(trial - {1'b0, div_q}) : trial[SW-1:0];
	assign done   = !busy_q;
	assign rem    = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(LFSR_W - 1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[LFSR_W-2:0], 1'b0};
			rem_q <= rem_nx;
		end
	end

endmodule

[sv/lesc_dp.sv]
// Datapath of the scheduler: stop lists, car state, LFSR and result register.
module lesc_dp import lesc_pkg::*; #(
	parameter int STOP_DEPTH = DEF_STOP_DEPTH,
	parameter int FLOOR_BITS = DEF_FLOOR_BITS,
	parameter int TAG_BITS   = DEF_TAG_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [FLOOR_BITS-1:0] call_floor,
	input  logic [1:0]            call_direction,
	input  logic [TAG_BITS-1:0]   call_tag,
	input  cmd_t                  cmd,
	output dp_stat_t              stat,
	input  logic                  out_ready,
	output logic                  out_valid,
	output logic [KIND_W-1:0]     kind,
	output logic [FLOOR_BITS-1:0] at_floor,
	output logic [DIR_W-1:0]      moving_dir,
	output logic [STAT_W-1:0]     car_status,
	output logic [LOAD_W-1:0]     load,
	output logic [TAG_BITS-1:0]   event_tag,
	output logic [FLOOR_BITS-1:0] dest_floor,
	output logic                  last
);

	localparam int IDX_W = $clog2(STOP_DEPTH);
	localparam int CNT_W = $clog2(STOP_DEPTH + 1);

	typedef struct packed {
		logic [FLOOR_BITS-1:0] floor;
		logic                  pickup;
		logic                  want_up;
		logic [TAG_BITS-1:0]   tag;
	} stop_t;

	// configuration and car state
	logic [FLOOR_BITS-1:0] gnd_q, top_q, car_q;
	dir_t                  dir_q;
	stat_t                 status_q;
	logic [LOAD_W-1:0]     onboard_q;
	logic [LFSR_W-1:0]     lfsr_q;

	// latched call
	logic [FLOOR_BITS-1:0] c_floor_q;
	logic [1:0]            c_dir_q;
	logic [TAG_BITS-1:0]   c_tag_q;

	// lists and sweep bookkeeping
	stop_t            up_q [STOP_DEPTH];
	stop_t            dn_q [STOP_DEPTH];
	stop_t            pend_q [STOP_DEPTH];
	logic [CNT_W-1:0] up_n_q, dn_n_q, idx_q, nk_q, npu_q, npd_q, npend_q, pidx_q;
	logic             sel_up_q;
	logic [FLOOR_BITS-1:0] umin_q, umax_q, dmin_q, dmax_q;
	logic             uminf_q, dmaxf_q;

	// output register
	logic                  ov_q;
	kind_t                 o_kind_q;
	logic [FLOOR_BITS-1:0] o_floor_q, o_dest_q;
	dir_t                  o_dir_q;
	stat_t                 o_stat_q;
	logic [LOAD_W-1:0]     o_load_q;
	logic [TAG_BITS-1:0]   o_tag_q;
	logic                  o_last_q;

	// combinational
	stop_t                 e, p;
	logic [IDX_W-1:0]      ix;
	logic [CNT_W-1:0]      sel_n, oth_n, pend_oth;
	logic                  rd_ok, at_stop, dup, same, blocked;
	dir_t                  dir1, dir2, dir_mv, dir_init;
	logic [FLOOR_BITS-1:0] car_mv, nu, nd, du, dd, span, target, rem;
	stat_t                 st_mv;
	logic                  call_bad, call_up, call_full, out_free, div_done, div_start;
	logic [LFSR_W-1:0]     lfsr_nx;
	logic [LOAD_W-1:0]     onboard_d;
	logic                  em;
	kind_t                 em_kind;
	stat_t                 em_stat;
	logic [TAG_BITS-1:0]   em_tag;
	logic [FLOOR_BITS-1:0] em_dest;

	assign ix    = idx_q[IDX_W-1:0];
	assign e     = sel_up_q ? up_q[ix] : dn_q[ix];
	assign p     = pend_q[pidx_q[IDX_W-1:0]];
	assign sel_n = sel_up_q ? up_n_q : dn_n_q;
	assign oth_n = sel_up_q ? dn_n_q : up_n_q;
	assign rd_ok = idx_q < sel_n;

	// serve decision for the entry under the index
	assign at_stop  = e.floor == car_q;
	assign dup      = e.want_up && (top_q > car_q);
	assign same     = dup == sel_up_q;
	assign pend_oth = dup ? npu_q : npd_q;
	assign blocked  = !same && ({1'b0, oth_n} + {1'b0, pend_oth} >= (CNT_W + 1)'(STOP_DEPTH));
	assign span     = e.want_up ? FLOOR_BITS'(top_q - car_q) : FLOOR_BITS'(car_q - gnd_q);
	assign lfsr_nx  = (lfsr_q >> 1) ^ (lfsr_q[0] ? LFSR_TAPS : '0);
	assign div_start = cmd.serve_step && stat.sv_pick;

	always_comb begin
		if (e.want_up) target = (top_q > car_q) ? FLOOR_BITS'(car_q + rem + 1'b1) : car_q;
		else target = (car_q > gnd_q) ? FLOOR_BITS'(gnd_q + rem) : car_q;
	end

	lesc_mod #(.SW(FLOOR_BITS)) u_mod (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(lfsr_nx),
		.divisor(span), .done(div_done), .rem(rem)
	);

	// boundary reversal at the start of a tick
	always_comb begin
		dir1 = (car_q >= top_q && dir_q == DIR_UP) ? DIR_DOWN : dir_q;
		dir2 = (car_q <= gnd_q && dir1 == DIR_DOWN) ? DIR_UP : dir1;
	end

	// nearest-stop choice from idle
	always_comb begin
		nu = uminf_q ? umin_q : umax_q;
		nd = dmaxf_q ? dmax_q : dmin_q;
		du = (nu >= car_q) ? FLOOR_BITS'(nu - car_q) : FLOOR_BITS'(car_q - nu);
		dd = (nd >= car_q) ? FLOOR_BITS'(nd - car_q) : FLOOR_BITS'(car_q - nd);
		priority if (up_n_q == '0 && dn_n_q == '0) dir_init = DIR_IDLE;
		else if (up_n_q == '0) dir_init = (nd > car_q) ? DIR_UP : DIR_DOWN;
		else if (dn_n_q == '0) dir_init = (nu > car_q) ? DIR_UP : DIR_DOWN;
		else dir_init = (du <= dd) ? DIR_UP : DIR_DOWN;
	end

	// one-floor move
	always_comb begin
		dir_mv = dir_q;
		car_mv = car_q;
		st_mv  = status_q;
		priority if (dir_q == DIR_UP && car_q >= top_q) dir_mv = DIR_IDLE;
		else if (dir_q == DIR_DOWN && car_q <= gnd_q) dir_mv = DIR_IDLE;
		else if (dir_q == DIR_UP) begin
			car_mv = car_q + 1'b1;
			st_mv  = ST_UP;
		end else if (dir_q == DIR_DOWN) begin
			car_mv = car_q - 1'b1;
			st_mv  = ST_DOWN;
		end
	end

	// hall call check
	always_comb begin
		call_bad  = c_floor_q < gnd_q || c_floor_q > top_q ||
			(c_dir_q != DIR_UP && c_dir_q != DIR_DOWN) ||
			(c_floor_q == top_q && c_dir_q == DIR_UP) ||
			(c_floor_q == gnd_q && c_dir_q == DIR_DOWN);
		call_up   = c_floor_q > car_q || (c_floor_q == car_q && c_dir_q == DIR_UP);
		call_full = (call_up ? up_n_q : dn_n_q) >= CNT_W'(STOP_DEPTH);
	end

	assign out_free = !ov_q || out_ready;

	always_comb begin
		stat.both_empty  = up_n_q == '0 && dn_n_q == '0;
		stat.rev_idle    = dir2 == DIR_IDLE;
		stat.scan_done   = !sel_up_q && !rd_ok;
		stat.serve_done  = !rd_ok;
		stat.sv_keep     = rd_ok && (!at_stop || (e.pickup && blocked));
		stat.sv_pick     = rd_ok && at_stop && e.pickup && !blocked;
		stat.sv_drop     = rd_ok && at_stop && !e.pickup;
		stat.div_done    = div_done;
		stat.append_done = pidx_q >= npend_q;
		stat.out_free    = out_free;
	end

	// result selection
	always_comb begin
		em        = 1'b0;
		em_kind   = KIND_SUM;
		em_stat   = status_q;
		em_tag    = '0;
		em_dest   = '0;
		onboard_d = onboard_q;
		if (cmd.call) begin
			em     = 1'b1;
			em_tag = c_tag_q;
			priority if (call_bad) em_kind = KIND_REJECT;
			else if (call_full) em_kind = KIND_FULL;
			else em_kind = KIND_ACCEPT;
		end else if (cmd.serve_step && stat.sv_drop) begin
			em        = 1'b1;
			em_kind   = KIND_DROPOFF;
			em_stat   = ST_DROPOFF;
			em_tag    = e.tag;
			onboard_d = (onboard_q != '0) ? onboard_q - 1'b1 : onboard_q;
		end else if (cmd.pick) begin
			em        = 1'b1;
			em_kind   = KIND_PICKUP;
			em_stat   = ST_PICKUP;
			em_tag    = e.tag;
			em_dest   = target;
			onboard_d = (onboard_q != '1) ? onboard_q + 1'b1 : onboard_q;
		end else if (cmd.sum) begin
			em = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gnd_q     <= FLOOR_BITS'(1);
			top_q     <= FLOOR_BITS'(10);
			lfsr_q    <= LFSR_ONE;
			car_q     <= FLOOR_BITS'(1);
			dir_q     <= DIR_IDLE;
			status_q  <= ST_IDLE;
			onboard_q <= '0;
			up_n_q    <= '0;
			dn_n_q    <= '0;
			idx_q     <= '0;
			nk_q      <= '0;
			npu_q     <= '0;
			npd_q     <= '0;
			npend_q   <= '0;
			pidx_q    <= '0;
			sel_up_q  <= 1'b0;
			uminf_q   <= 1'b0;
			dmaxf_q   <= 1'b0;
			ov_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					CFG_GROUND: gnd_q <= cfg_data[FLOOR_BITS-1:0];
					CFG_TOP:    top_q <= cfg_data[FLOOR_BITS-1:0];
					CFG_SEED:   lfsr_q <= (cfg_data == '0) ? LFSR_ONE : cfg_data;
					default:    ;
				endcase
			end
			onboard_q <= onboard_d;
			if (em) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;

			if (cmd.call && !call_bad && !call_full) begin
				if (call_up) up_n_q <= up_n_q + 1'b1;
				else dn_n_q <= dn_n_q + 1'b1;
			end
			if (cmd.tick) begin
				dir_q    <= dir2;
				sel_up_q <= 1'b1;
				idx_q    <= '0;
				uminf_q  <= 1'b0;
				dmaxf_q  <= 1'b0;
			end
			if (cmd.scan) begin
				if (rd_ok) begin
					idx_q <= idx_q + 1'b1;
					if (sel_up_q && e.floor >= car_q && (!uminf_q || e.floor < umin_q))
						uminf_q <= 1'b1;
					if (!sel_up_q && e.floor <= car_q && (!dmaxf_q || e.floor > dmax_q))
						dmaxf_q <= 1'b1;
				end else if (sel_up_q) begin
					sel_up_q <= 1'b0;
					idx_q    <= '0;
				end else begin
					dir_q <= dir_init;
				end
			end
			if (cmd.move) begin
				car_q    <= car_mv;
				dir_q    <= dir_mv;
				status_q <= st_mv;
				sel_up_q <= dir_mv == DIR_UP;
				idx_q    <= '0;
				nk_q     <= '0;
				npu_q    <= '0;
				npd_q    <= '0;
				npend_q  <= '0;
			end
			if (cmd.serve_step) begin
				if (stat.sv_keep) begin
					nk_q  <= nk_q + 1'b1;
					idx_q <= idx_q + 1'b1;
				end else if (stat.sv_drop) begin
					status_q <= ST_DROPOFF;
					idx_q    <= idx_q + 1'b1;
				end else begin
					lfsr_q <= lfsr_nx;
				end
			end
			if (cmd.pick) begin
				idx_q   <= idx_q + 1'b1;
				npend_q <= npend_q + 1'b1;
				if (dup) npu_q <= npu_q + 1'b1;
				else npd_q <= npd_q + 1'b1;
			end
			if (cmd.serve_end) begin
				if (sel_up_q) up_n_q <= nk_q;
				else dn_n_q <= nk_q;
				pidx_q <= '0;
			end
			if (cmd.append) begin
				pidx_q <= pidx_q + 1'b1;
				if (p.want_up && up_n_q < CNT_W'(STOP_DEPTH)) up_n_q <= up_n_q + 1'b1;
				if (!p.want_up && dn_n_q < CNT_W'(STOP_DEPTH)) dn_n_q <= dn_n_q + 1'b1;
			end
			if (cmd.turn && (dir_q == DIR_UP ? up_n_q : dn_n_q) == '0) begin
				if ((dir_q == DIR_UP ? dn_n_q : up_n_q) != '0) begin
					dir_q <= (dir_q == DIR_UP) ? DIR_DOWN : DIR_UP;
				end else begin
					dir_q    <= DIR_IDLE;
					status_q <= ST_IDLE;
				end
			end
		end
	end

	// payload storage, no reset
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			c_floor_q <= call_floor;
			c_dir_q   <= call_direction;
			c_tag_q   <= call_tag;
		end
		if (cmd.tick) begin
			umax_q <= '0;
			dmin_q <= '1;
		end
		if (cmd.scan && rd_ok) begin
			if (sel_up_q) begin
				if (e.floor >= car_q && (!uminf_q || e.floor < umin_q)) umin_q <= e.floor;
				if (e.floor > umax_q) umax_q <= e.floor;
			end else begin
				if (e.floor <= car_q && (!dmaxf_q || e.floor > dmax_q)) dmax_q <= e.floor;
				if (e.floor < dmin_q) dmin_q <= e.floor;
			end
		end
		if (cmd.call && !call_bad && !call_full) begin
			if (call_up) up_q[up_n_q[IDX_W-1:0]] <= {c_floor_q, 1'b1, c_dir_q == DIR_UP, c_tag_q};
			else dn_q[dn_n_q[IDX_W-1:0]] <= {c_floor_q, 1'b1, c_dir_q == DIR_UP, c_tag_q};
		end
		if (cmd.serve_step && stat.sv_keep) begin
			if (sel_up_q) up_q[nk_q[IDX_W-1:0]] <= e;
			else dn_q[nk_q[IDX_W-1:0]] <= e;
		end
		if (cmd.pick) pend_q[npend_q[IDX_W-1:0]] <= {target, 1'b0, dup, e.tag};
		if (cmd.append) begin
			if (p.want_up && up_n_q < CNT_W'(STOP_DEPTH)) up_q[up_n_q[IDX_W-1:0]] <= p;
			if (!p.want_up && dn_n_q < CNT_W'(STOP_DEPTH)) dn_q[dn_n_q[IDX_W-1:0]] <= p;
		end
		if (em) begin
			o_kind_q  <= em_kind;
			o_floor_q <= car_q;
			o_dir_q   <= dir_q;
			o_stat_q  <= em_stat;
			o_load_q  <= onboard_d;
			o_tag_q   <= em_tag;
			o_dest_q  <= em_dest;
			o_last_q  <= cmd.call || cmd.sum;
		end
	end

	assign out_valid  = ov_q;
	assign kind       = o_kind_q;
	assign at_floor   = o_floor_q;
	assign moving_dir = o_dir_q;
	assign car_status = o_stat_q;
	assign load       = o_load_q;
	assign event_tag  = o_tag_q;
	assign dest_floor = o_dest_q;
	assign last       = o_last_q;

endmodule

[sv/look_elevator_scheduler_core.sv]
// LOOK elevator scheduler, top level; one item in flight, results via a one-item register.
// Hall call: one result, registered in S_CALL once the result register is free.
// Tick: reversal, a scan of both lists (from idle only), a one-floor move, a serve step
//   per stop in the active list, a remainder wait and emit per pickup, an append per new
//   drop-off, turn and summary; only the summary if both lists are empty; stalls hold emits.
// Reset (async, low): lists empty, car idle at floor 1, load 0, LFSR 1, floors 1..10.
module look_elevator_scheduler_core import lesc_pkg::*; #(
	parameter int STOP_DEPTH = DEF_STOP_DEPTH,
	parameter int FLOOR_BITS = DEF_FLOOR_BITS,
	parameter int TAG_BITS   = DEF_TAG_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	lesc_call_if.sink             req,
	lesc_res_if.source            rsp
);

	cmd_t     cmd;
	dp_stat_t stat;

	// the sequencer owns the input handshake; mode picks call or tick
	lesc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(req.valid), .in_mode(req.mode), .in_ready(req.ready),
		.cmd(cmd), .stat(stat)
	);

	// lists, car state, LFSR and the result register
	lesc_dp #(
		.STOP_DEPTH(STOP_DEPTH), .FLOOR_BITS(FLOOR_BITS), .TAG_BITS(TAG_BITS)
	) u_dp (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.call_floor(req.call_floor), .call_direction(req.call_direction),
		.call_tag(req.call_tag),
		.cmd(cmd), .stat(stat),
		.out_ready(rsp.ready), .out_valid(rsp.valid),
		.kind(rsp.kind), .at_floor(rsp.at_floor), .moving_dir(rsp.moving_dir),
		.car_status(rsp.car_status), .load(rsp.load), .event_tag(rsp.event_tag),
		.dest_floor(rsp.dest_floor), .last(rsp.last)
	);

endmodule

[sv/lesc_chk.sv]
// Port-level checks of the scheduler, bound to the top level.
module lesc_chk import lesc_pkg::*; #(
	parameter int TAG_BITS = DEF_TAG_BITS
) (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input logic [KIND_W-1:0]   kind,
	input logic                last,
	input logic [TAG_BITS-1:0] event_tag
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("second item taken while busy");

	a_sum: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_SUM |-> last && event_tag == '0)
		else $error("tick summary malformed");

	a_mid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_PICKUP || kind == KIND_DROPOFF) |-> !last)
		else $error("stop event marked last");

	a_call: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_ACCEPT || kind == KIND_REJECT || kind == KIND_FULL)
		|-> last) else $error("call result not last");

endmodule

bind look_elevator_scheduler_core lesc_chk #(.TAG_BITS(TAG_BITS)) u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(req.valid), .in_ready(req.ready),
	.out_valid(rsp.valid), .out_ready(rsp.ready),
	.kind(rsp.kind), .last(rsp.last), .event_tag(rsp.event_tag)
);

[tb/lesc_tb_if.sv]
// Testbench package: the type that carries one expected scheduler event.
package lesc_tb_pkg;
	import lesc_pkg::*;

	typedef struct packed {
		kind_t      kind;
		logic [5:0] at_floor;
		dir_t       moving_dir;
		stat_t      car_status;
		logic [5:0] load;
		logic [7:0] event_tag;
		logic [5:0] dest_floor;
		logic       last;
	} event_t;
endpackage

[tb/lesc_checker.sv]
// Scheduler predictor and event comparator.
module lesc_checker import lesc_pkg::*; import lesc_tb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_fire,
	input  logic                  in_mode,
	input  logic [5:0]            in_floor,
	input  logic [1:0]            in_dir,
	input  logic [7:0]            in_tag,
	input  logic                  out_fire,
	input  event_t                out_ev,
	output int                    pending,
	output int                    fails
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [5:0] floor;
		logic       pickup;
		logic       want_up;
		logic [7:0] tag;
	} stop_t;

	stop_t      ups[$], downs[$];
	int         gnd, top, car, dir, stat, riders;
	logic [15:0] lfsr;
	event_t     due[$];

	assign pending = due.size();

	task automatic report(input string msg);
		$display("mismatch: %s", msg);
		fails++;
	endtask

	function automatic void post(kind_t k, int st, int tag, int dst);
		event_t e;
		e.kind = k; e.at_floor = car[5:0]; e.moving_dir = dir_t'(dir[1:0]);
		e.car_status = stat_t'(st[2:0]); e.load = riders[5:0];
		e.event_tag = tag[7:0]; e.dest_floor = dst[5:0]; e.last = 1'b0;
		due.insert(due.size(), e);
	endfunction

	function automatic int pick_dir();
		int nu, nd, umin, umax, dmin, dmax, du, dd;
		nu = -1; nd = -1; umin = -1; umax = -1; dmin = -1; dmax = -1;
		foreach (ups[i]) begin
			if (ups[i].floor >= car && (umin < 0 || ups[i].floor < umin)) umin = ups[i].floor;
			if (umax < 0 || ups[i].floor > umax) umax = ups[i].floor;
		end
		foreach (downs[i]) begin
			if (downs[i].floor <= car && (dmax < 0 || downs[i].floor > dmax))
				dmax = downs[i].floor;
			if (dmin < 0 || downs[i].floor < dmin) dmin = downs[i].floor;
		end
		if (ups.size() > 0) nu = (umin >= 0) ? umin : umax;
		if (downs.size() > 0) nd = (dmax >= 0) ? dmax : dmin;
		if (nu < 0 && nd < 0) return DIR_IDLE;
		if (nu < 0) return (nd > car) ? DIR_UP : DIR_DOWN;
		if (nd < 0) return (nu > car) ? DIR_UP : DIR_DOWN;
		du = nu - car; dd = nd - car;
		if (du < 0) du = -du;
		if (dd < 0) dd = -dd;
		return (du <= dd) ? DIR_UP : DIR_DOWN;
	endfunction

	// Serve the active list at the current floor; new drop-offs go behind kept stops.
	function automatic void serve_floor();
		stop_t cur[$], kept[$], pu[$], pd[$], d;
		int n_oth, tgt, span;
		bit act_up, dup;
		logic [15:0] r;
		act_up = (dir == DIR_UP);
		cur = act_up ? ups : downs;
		n_oth = act_up ? downs.size() : ups.size();
		foreach (cur[i]) begin
			if (cur[i].floor != car) begin
				kept.insert(kept.size(), cur[i]);
			end else if (cur[i].pickup) begin
				dup = cur[i].want_up && top > car;
				if (dup != act_up && n_oth + (dup ? pu.size() : pd.size()) >= 16) begin
					kept.insert(kept.size(), cur[i]);
					continue;
				end
				r = {1'b0, lfsr[15:1]} ^ (lfsr[0] ? LFSR_TAPS : 16'h0);
				lfsr = r;
				if (cur[i].want_up) begin
					span = top - car;
					tgt = (span > 0) ? car + int'(r % span) + 1 : car;
				end else begin
					span = car - gnd;
					tgt = (span > 0) ? gnd + int'(r % span) : car;
				end
				if (riders < 63) riders++;
				d.floor = tgt[5:0]; d.pickup = 0; d.want_up = dup; d.tag = cur[i].tag;
				if (dup) pu.insert(pu.size(), d); else pd.insert(pd.size(), d);
				post(KIND_PICKUP, ST_PICKUP, cur[i].tag, tgt);
			end else begin
				if (riders > 0) riders--;
				stat = ST_DROPOFF;
				post(KIND_DROPOFF, ST_DROPOFF, cur[i].tag, 0);
			end
		end
		if (act_up) ups = kept; else downs = kept;
		foreach (pu[i]) if (ups.size() < 16) ups.insert(ups.size(), pu[i]);
		foreach (pd[i]) if (downs.size() < 16) downs.insert(downs.size(), pd[i]);
	endfunction

	function automatic void predict(bit m, int f, int d, int tag);
		bit bad, to_up;
		int first;
		first = due.size();
		if (!m) begin
			bad = f < gnd || f > top || (d != 1 && d != 2) || (f == top && d == 1) ||
				(f == gnd && d == 2);
			to_up = (f > car) || (f == car && d == 1);
			if (bad) post(KIND_REJECT, stat, tag, 0);
			else if ((to_up ? ups.size() : downs.size()) >= 16) post(KIND_FULL, stat, tag, 0);
			else begin
				if (to_up) ups.insert(ups.size(), {f[5:0], 1'b1, d == 1, tag[7:0]});
				else downs.insert(downs.size(), {f[5:0], 1'b1, d == 1, tag[7:0]});
				post(KIND_ACCEPT, stat, tag, 0);
			end
		end else begin
			if (ups.size() > 0 || downs.size() > 0) begin
				if (car >= top && dir == DIR_UP) dir = DIR_DOWN;
				if (car <= gnd && dir == DIR_DOWN) dir = DIR_UP;
				if (dir == DIR_IDLE) dir = pick_dir();
				if (dir == DIR_UP && car >= top) dir = DIR_IDLE;
				else if (dir == DIR_DOWN && car <= gnd) dir = DIR_IDLE;
				else if (dir == DIR_UP) begin car++; stat = ST_UP; end
				else if (dir == DIR_DOWN) begin car--; stat = ST_DOWN; end
				serve_floor();
				if ((dir == DIR_UP ? ups.size() : downs.size()) == 0) begin
					if ((dir == DIR_UP ? downs.size() : ups.size()) != 0)
						dir = (dir == DIR_UP) ? DIR_DOWN : DIR_UP;
					else begin
						dir = DIR_IDLE; stat = ST_IDLE;
					end
				end
			end
			post(KIND_SUM, stat, 0, 0);
		end
		due[due.size()-1].last = 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		event_t w;
		if (!arst_n) begin
			ups.delete(); downs.delete(); due.delete();
			gnd = 1; top = 10; car = 1; dir = DIR_IDLE; stat = ST_IDLE; riders = 0;
			lfsr = 16'd1; fails = 0;
		end else begin
			if (out_fire) begin
				if (due.size() == 0) report($sformatf("unexpected event kind %0d", out_ev.kind));
				else begin
					w = due.pop_front();
					if (out_ev.kind !== w.kind)
						report($sformatf("kind %0d want %0d", out_ev.kind, w.kind));
					if (out_ev.at_floor !== w.at_floor)
						report($sformatf("floor %0d want %0d", out_ev.at_floor, w.at_floor));
					if (out_ev.moving_dir !== w.moving_dir)
						report($sformatf("dir %0d want %0d", out_ev.moving_dir, w.moving_dir));
					if (out_ev.car_status !== w.car_status)
						report($sformatf("status %0d want %0d", out_ev.car_status, w.car_status));
					if (out_ev.load !== w.load)
						report($sformatf("load %0d want %0d", out_ev.load, w.load));
					if (out_ev.event_tag !== w.event_tag)
						report($sformatf("tag %0d want %0d", out_ev.event_tag, w.event_tag));
					if (out_ev.dest_floor !== w.dest_floor)
						report($sformatf("dest %0d want %0d", out_ev.dest_floor, w.dest_floor));
					if (out_ev.last !== w.last)
						report($sformatf("last %0b want %0b", out_ev.last, w.last));
				end
			end
			if (cfg_we) begin
				case (cfg_t'(cfg_idx))
					CFG_GROUND: gnd = cfg_data[5:0];
					CFG_TOP:    top = cfg_data[5:0];
					CFG_SEED:   lfsr = (cfg_data == 0) ? LFSR_ONE : cfg_data;
					default: ;
				endcase
			end
			if (in_fire) predict(in_mode, in_floor, in_dir, in_tag);
		end
	end
endmodule

[tb/tb_top.sv]
// Testbench top: stimulus, configuration phases and verdict.
module tb_top import lesc_pkg::*; import lesc_tb_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 20000;   // cycles with no item moving on either side

	logic                  clk = 0, arst_n = 0;
	logic                  cfg_we = 0;
	logic [CFG_IDX_W-1:0]  cfg_idx = CFG_GROUND;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	int                    pending, fails, quiet;
	int                    gnd_now, top_now;
	event_t                got;

	lesc_call_if req ();
	lesc_res_if  rsp ();

	look_elevator_scheduler_core u_top (.clk, .arst_n, .cfg_we, .cfg_idx, .cfg_data,
		.req(req.sink), .rsp(rsp.source));

	assign got = '{kind_t'(rsp.kind), rsp.at_floor, dir_t'(rsp.moving_dir),
		stat_t'(rsp.car_status), rsp.load, rsp.event_tag, rsp.dest_floor, rsp.last};

	lesc_checker u_chk (.clk, .arst_n, .cfg_we, .cfg_idx, .cfg_data,
		.in_fire(req.valid && req.ready), .in_mode(req.mode), .in_floor(req.call_floor),
		.in_dir(req.call_direction), .in_tag(req.call_tag),
		.out_fire(rsp.valid && rsp.ready), .out_ev(got), .pending, .fails);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	initial begin
		req.valid = 0; req.mode = 0; req.call_floor = '0; req.call_direction = '0;
		req.call_tag = '0; rsp.ready = 0;
	end

	// Receiver: random stall before each event, with calm stretches.
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
			if (gap > 0) begin
				rsp.ready <= 0;
				repeat (gap) @(posedge clk);
			end
			rsp.ready <= 1;
			do @(posedge clk); while (!rsp.valid);
		end
	end

	// Watchdog on cycles where neither side moves an item.
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || cfg_we)
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet > IDLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic send(input bit m, input int f, input int d, input int tag, input bit gaps);
		int gap;
		gap = gaps ? $urandom_range(0, 19) : 0;
		if (gaps && $urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			req.valid <= 0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1; req.mode <= m; req.call_floor <= f[5:0];
		req.call_direction <= d[1:0]; req.call_tag <= tag[7:0];
		do @(posedge clk); while (!req.ready);
	endtask

	task automatic drain_and_write(input cfg_t idx, input int val);
		req.valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (150) @(posedge clk);   // tick work with no result still under way
		cfg_we <= 1; cfg_idx <= idx; cfg_data <= val[15:0];
		@(posedge clk);
		cfg_we <= 0;
		if (idx == CFG_GROUND) gnd_now = val[5:0];
		if (idx == CFG_TOP) top_now = val[5:0];
	endtask

	// Mostly valid calls around the served range, plus noise; ticks to move the car.
	task automatic random_burst(input int count);
		int f, d;
		repeat (count) begin
			if ($urandom_range(0, 9) < 5) send(1, $urandom, $urandom, $urandom, 1);
			else begin
				if ($urandom_range(0, 9) == 0) begin
					f = $urandom_range(0, 63); d = $urandom_range(0, 3);
				end else begin
					f = (top_now >= gnd_now) ? $urandom_range(gnd_now, top_now) : gnd_now;
					d = $urandom_range(1, 2);
				end
				send(0, f, d, $urandom, 1);
			end
		end
	endtask

	initial begin
		gnd_now = 1; top_now = 10;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: field extremes, both bad directions, boundary rejects, ticks when empty
		send(1, 0, 0, 0, 0);
		send(0, 0, 1, 8'h00, 0);
		send(0, 63, 2, 8'hff, 0);
		send(0, 5, 0, 8'h55, 0);
		send(0, 5, 3, 8'haa, 0);
		send(0, 10, 1, 1, 0);
		send(0, 1, 2, 2, 0);
		send(0, 1, 1, 3, 0);
		send(0, 10, 2, 4, 0);
		send(0, 5, 1, 5, 0);
		send(0, 5, 2, 6, 0);
		repeat (12) send(1, 63, 3, 255, 0);
		// fill the up list past capacity
		for (int i = 0; i < 17; i++) send(0, 2 + i % 8, 1, 100 + i, 0);
		repeat (30) send(1, 0, 0, 0, 1);
		random_burst(30);
		drain_and_write(CFG_SEED, 16'hffff);
		drain_and_write(CFG_GROUND, 0);
		drain_and_write(CFG_TOP, 63);
		random_burst(30);
		drain_and_write(CFG_SEED, 0);
		drain_and_write(CFG_GROUND, 20);
		drain_and_write(CFG_TOP, 24);
		random_burst(20);
		// ground above top: car must stay put at the boundaries
		drain_and_write(CFG_GROUND, 30);
		drain_and_write(CFG_TOP, 3);
		random_burst(10);
		drain_and_write(CFG_GROUND, 63);
		drain_and_write(CFG_TOP, 63);
		drain_and_write(CFG_SEED, 16'h1234);
		random_burst(8);
		drain_and_write(CFG_GROUND, 1);
		drain_and_write(CFG_TOP, 10);
		random_burst(12);
		req.valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (fails == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
